// File: hw/rtl/bgp_unique_path_attr_generator_macros.svh
// Assertion macros used by the checker file.
`ifndef BGP_UNIQUE_PATH_ATTR_GENERATOR_MACROS_SVH
`define BGP_UNIQUE_PATH_ATTR_GENERATOR_MACROS_SVH

// Plain property, checked on every edge outside reset.
`define BUPA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bupa assertion failed");

// A stalled valid holds, and so does its payload.
`define BUPA_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		vld && !rdy |=> vld && $stable(sig)) \
		else $error("bupa stalled item changed");

`endif

// File: hw/rtl/bupa_pkg.sv
`default_nettype none
package bupa_pkg;

	localparam int MAX_PATH_LEN_DEF = 200;
	localparam int MAX_COMMS_DEF    = 16;
	localparam int MAX_ECOMMS_DEF   = 4;

	// Widths cover the full parameter ranges.
	localparam int NC_W  = 7;
	localparam int NE_W  = 6;
	localparam int PL_W  = 8;
	localparam int TOT_W = 10;
	localparam int RAW_W = 11;

	localparam logic [RAW_W-1:0] OUT_CAP = 11'd512;

	localparam logic [7:0] FLAG_TRANS     = 8'h40;
	localparam logic [7:0] FLAG_TRANS_EXT = 8'h50;
	localparam logic [7:0] FLAG_OPT       = 8'hc0;
	localparam logic [7:0] FLAG_OPT_EXT   = 8'hd0;
	localparam logic [7:0] TYPE_AS_PATH   = 8'h02;
	localparam logic [7:0] SEG_SEQ        = 8'h02;
	localparam logic [7:0] TYPE_COMM      = 8'h08;
	localparam logic [7:0] TYPE_ECOMM     = 8'h10;
	localparam logic [31:0] ECOMM_PREFIX  = 32'h4003_0101;

	localparam logic [15:0] FILLER_BASE   = 16'd50;
	localparam logic [15:0] PATH_LOW_BASE = 16'd1000;
	localparam logic [15:0] PATH_LOW_WRAP = 16'd2000;
	localparam logic [15:0] COMM_BASE     = 16'd10000;
	localparam logic [15:0] COMM_LIMIT    = 16'd60000;
	localparam logic [15:0] ECOMM_LIMIT   = 16'd50000;

	localparam int FIFO_DEPTH = 2;

	typedef enum logic [2:0] {
		REG_PATH_LEN        = 3'd0,
		REG_LOCAL_ASN       = 3'd1,
		REG_PATH_LOW_START  = 3'd2,
		REG_PATH_HIGH_START = 3'd3,
		REG_COMM_HIGH_START = 3'd4,
		REG_COMM_LOW_START  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [4:0] comm_count;
		logic [2:0] ecomm_count;
	} in_t;

	typedef struct packed {
		logic [63:0]      word;
		logic [3:0]       byte_count;
		logic             last;
		logic [TOT_W-1:0] total_bytes;
	} out_t;

	typedef struct packed {
		logic        en;
		reg_idx_t    idx;
		logic [15:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [7:0]  path_len;
		logic [15:0] local_asn;
		logic [10:0] path_low_start;
		logic [15:0] path_high_start;
		logic [15:0] comm_high_start;
		logic [15:0] comm_low_start;
	} cfg_regs_t;

	typedef struct packed {
		logic [NC_W-1:0]  nc;
		logic [NE_W-1:0]  ne;
		logic [PL_W-1:0]  pl;
		logic [15:0]      local_asn;
		logic [15:0]      plow;
		logic [15:0]      phigh;
		logic [15:0]      chigh;
		logic [15:0]      clow;
		logic [TOT_W-1:0] total;
	} desc_t;

	// One community counter step: returns {high, low}.
	function automatic logic [31:0] comm_step(input logic [15:0] high, input logic [15:0] low,
		input logic [15:0] limit);
		logic [16:0] nxt;
		nxt = {1'b0, low} + 17'd1;
		if (nxt > {1'b0, limit})
			return {high + 16'd1, COMM_BASE};
		else
			return {high, nxt[15:0]};
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bupa_fifo.sv
`default_nettype none
module bupa_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  bupa_pkg::desc_t     push_data,
	output logic                full,
	input  wire logic           pop,
	output bupa_pkg::desc_t     pop_data,
	output logic                not_empty
);
	import bupa_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	desc_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full      = cnt_q == CNT_W'(FIFO_DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/bupa_front.sv
`default_nettype none
module bupa_front #(
	parameter int MAX_PATH_LEN = bupa_pkg::MAX_PATH_LEN_DEF,
	parameter int MAX_COMMS    = bupa_pkg::MAX_COMMS_DEF,
	parameter int MAX_ECOMMS   = bupa_pkg::MAX_ECOMMS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  bupa_pkg::cfg_wr_t    cfg_wr,
	output bupa_pkg::cfg_regs_t  cfg_regs,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  bupa_pkg::in_t        in_data,
	output logic                 push,
	output bupa_pkg::desc_t      push_data,
	input  wire logic            full
);
	import bupa_pkg::*;

	cfg_regs_t        cfg_q;
	logic [15:0]      plow_q, phigh_q, chigh_q, clow_q;
	logic             busy_q;
	logic [NC_W-1:0]  rem_c_q;
	logic [NE_W-1:0]  rem_e_q;

	logic [NC_W-1:0]  nc;
	logic [NE_W-1:0]  ne;
	logic [PL_W-1:0]  pl;
	logic [RAW_W-1:0] plen, pbytes, clen, cbytes, elen, ebytes, raw_total;
	logic [15:0]      plow_nxt;
	logic [31:0]      step;
	logic             finishing;

	assign cfg_regs = cfg_q;
	assign in_ready = !busy_q && !full;
	assign push     = in_valid && in_ready;

	// Clamp the request and the path length.
	always_comb begin
		nc = NC_W'(in_data.comm_count);
		if (nc > NC_W'(MAX_COMMS))
			nc = NC_W'(MAX_COMMS);
		ne = NE_W'(in_data.ecomm_count);
		if (ne > NE_W'(MAX_ECOMMS))
			ne = NE_W'(MAX_ECOMMS);
		pl = cfg_q.path_len;
		if (pl < 8'd3)
			pl = 8'd3;
		if (pl > PL_W'(MAX_PATH_LEN))
			pl = PL_W'(MAX_PATH_LEN);
	end

	// Image length: each attribute header is 3 bytes, 4 with a 2-byte length.
	always_comb begin
		plen   = RAW_W'({pl, 1'b0}) + 11'd2;
		pbytes = plen + ((plen > 11'd255) ? 11'd4 : 11'd3);
		clen   = RAW_W'(nc) << 2;
		cbytes = (nc == '0) ? '0 : clen + ((clen > 11'd255) ? 11'd4 : 11'd3);
		elen   = RAW_W'(ne) << 3;
		ebytes = (ne == '0) ? '0 : elen + ((elen > 11'd255) ? 11'd4 : 11'd3);
		raw_total = pbytes + cbytes + ebytes;
	end

	always_comb begin
		push_data.nc        = nc;
		push_data.ne        = ne;
		push_data.pl        = pl;
		push_data.local_asn = cfg_q.local_asn;
		push_data.plow      = plow_q;
		push_data.phigh     = phigh_q;
		push_data.chigh     = chigh_q;
		push_data.clow      = clow_q;
		push_data.total     = (raw_total > OUT_CAP) ? TOT_W'(OUT_CAP) : raw_total[TOT_W-1:0];
	end

	assign plow_nxt  = plow_q + 16'd1;
	assign step      = comm_step(chigh_q, clow_q, (rem_c_q != '0) ? COMM_LIMIT : ECOMM_LIMIT);
	assign finishing = (rem_c_q == NC_W'(1) && rem_e_q == '0) ||
		(rem_c_q == '0 && rem_e_q == NE_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.path_len        <= 8'd3;
			cfg_q.local_asn       <= '0;
			cfg_q.path_low_start  <= 11'd1000;
			cfg_q.path_high_start <= '0;
			cfg_q.comm_high_start <= '0;
			cfg_q.comm_low_start  <= COMM_BASE;
			plow_q  <= PATH_LOW_BASE;
			phigh_q <= '0;
			chigh_q <= '0;
			clow_q  <= COMM_BASE;
			busy_q  <= 1'b0;
			rem_c_q <= '0;
			rem_e_q <= '0;
		end else begin
			if (cfg_wr.en) begin
				case (cfg_wr.idx)
					REG_PATH_LEN: cfg_q.path_len <= cfg_wr.data[7:0];
					REG_LOCAL_ASN: cfg_q.local_asn <= cfg_wr.data;
					REG_PATH_LOW_START: begin
						cfg_q.path_low_start <= cfg_wr.data[10:0];
						plow_q <= {5'd0, cfg_wr.data[10:0]};
					end
					REG_PATH_HIGH_START: begin
						cfg_q.path_high_start <= cfg_wr.data;
						phigh_q <= cfg_wr.data;
					end
					REG_COMM_HIGH_START: begin
						cfg_q.comm_high_start <= cfg_wr.data;
						chigh_q <= cfg_wr.data;
					end
					REG_COMM_LOW_START: begin
						cfg_q.comm_low_start <= cfg_wr.data;
						clow_q <= cfg_wr.data;
					end
					default: ;
				endcase
			end
			if (push) begin
				// Advance the path pair once per request.
				if (plow_nxt >= PATH_LOW_WRAP) begin
					plow_q  <= PATH_LOW_BASE;
					phigh_q <= phigh_q + 16'd1;
				end else begin
					plow_q <= plow_nxt;
				end
				rem_c_q <= nc;
				rem_e_q <= ne;
				busy_q  <= (nc != '0) || (ne != '0);
			end else if (busy_q) begin
				// Step the community pair once per community or extended community.
				chigh_q <= step[31:16];
				clow_q  <= step[15:0];
				if (rem_c_q != '0)
					rem_c_q <= rem_c_q - 1'b1;
				else
					rem_e_q <= rem_e_q - 1'b1;
				if (finishing)
					busy_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/bupa_back.sv
`default_nettype none
module bupa_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pop_valid,
	output logic             pop,
	input  bupa_pkg::desc_t  desc,
	output logic             out_valid,
	input  wire logic        out_ready,
	output bupa_pkg::out_t   out_data
);
	import bupa_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_PATH_HDR  = 7'b0000010,
		ST_PATH_ASN  = 7'b0000100,
		ST_COMM_HDR  = 7'b0001000,
		ST_COMM      = 7'b0010000,
		ST_ECOMM_HDR = 7'b0100000,
		ST_ECOMM     = 7'b1000000
	} st_t;

	st_t              st_q, nxt_st;
	desc_t            d_q;
	logic [2:0]       sub_q;
	logic [7:0]       idx_q;
	logic [15:0]      ch_q, cl_q;
	logic [TOT_W-1:0] pos_q;
	logic [63:0]      acc_q, acc_new;
	logic [2:0]       acc_n_q;
	logic [3:0]       acc_n_new;
	out_t             out_q;
	logic             out_valid_q;

	logic [15:0] plen, clen, elen, asn;
	logic        p_ext, c_ext, e_ext;
	logic [2:0]  p_hn, c_hn, e_hn;
	logic [7:0]  cur_byte;
	logic        seg_end, entry_end, adv, img_last, flush;
	logic [31:0] step;
	st_t         after_path, after_comm;

	function automatic logic [7:0] hdr_byte(input logic [7:0] flags, input logic [7:0] typ,
		input logic [15:0] len, input logic ext, input logic [2:0] k);
		logic [7:0] b;
		case (k)
			3'd0: b = flags;
			3'd1: b = typ;
			3'd2: b = ext ? len[15:8] : len[7:0];
			3'd3: b = len[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	assign pop       = (st_q == ST_IDLE) && pop_valid;
	assign adv       = (st_q != ST_IDLE) && (!out_valid_q || out_ready);
	assign img_last  = (pos_q + 10'd1) == d_q.total;
	assign acc_n_new = {1'b0, acc_n_q} + 4'd1;
	assign flush     = (acc_n_new == 4'd8) || img_last;
	assign acc_new   = acc_q | ({56'd0, cur_byte} << {3'(3'd7 - acc_n_q), 3'b000});
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		plen  = 16'({d_q.pl, 1'b0}) + 16'd2;
		clen  = 16'(d_q.nc) << 2;
		elen  = 16'(d_q.ne) << 3;
		p_ext = plen > 16'd255;
		c_ext = clen > 16'd255;
		e_ext = elen > 16'd255;
		p_hn  = p_ext ? 3'd4 : 3'd3;
		c_hn  = c_ext ? 3'd4 : 3'd3;
		e_hn  = e_ext ? 3'd4 : 3'd3;
		after_comm = (d_q.ne != '0) ? ST_ECOMM_HDR : ST_IDLE;
		after_path = (d_q.nc != '0) ? ST_COMM_HDR : after_comm;
		if (idx_q == 8'd0)
			asn = d_q.local_asn;
		else if (idx_q == 8'(d_q.pl - 8'd1))
			asn = d_q.phigh;
		else if (idx_q == 8'(d_q.pl - 8'd2))
			asn = d_q.plow;
		else
			asn = FILLER_BASE + 16'(idx_q) - 16'd1;
	end

	always_comb begin
		cur_byte  = 8'h00;
		seg_end   = 1'b0;
		entry_end = 1'b0;
		nxt_st    = ST_IDLE;
		case (st_q)
			ST_PATH_HDR: begin
				if (sub_q < p_hn)
					cur_byte = hdr_byte(p_ext ? FLAG_TRANS_EXT : FLAG_TRANS, TYPE_AS_PATH,
						plen, p_ext, sub_q);
				else if (sub_q == p_hn)
					cur_byte = SEG_SEQ;
				else
					cur_byte = d_q.pl;
				seg_end = sub_q == 3'(p_hn + 3'd1);
				nxt_st  = ST_PATH_ASN;
			end
			ST_PATH_ASN: begin
				cur_byte  = sub_q[0] ? asn[7:0] : asn[15:8];
				entry_end = sub_q[0];
				seg_end   = sub_q[0] && (idx_q == 8'(d_q.pl - 8'd1));
				nxt_st    = after_path;
			end
			ST_COMM_HDR: begin
				cur_byte = hdr_byte(c_ext ? FLAG_OPT_EXT : FLAG_OPT, TYPE_COMM, clen, c_ext,
					sub_q);
				seg_end  = sub_q == 3'(c_hn - 3'd1);
				nxt_st   = ST_COMM;
			end
			ST_COMM: begin
				case (sub_q[1:0])
					2'd0: cur_byte = ch_q[15:8];
					2'd1: cur_byte = ch_q[7:0];
					2'd2: cur_byte = cl_q[15:8];
					default: cur_byte = cl_q[7:0];
				endcase
				entry_end = sub_q[1:0] == 2'd3;
				seg_end   = entry_end && (idx_q == 8'(d_q.nc - 1'b1));
				nxt_st    = after_comm;
			end
			ST_ECOMM_HDR: begin
				cur_byte = hdr_byte(e_ext ? FLAG_OPT_EXT : FLAG_OPT, TYPE_ECOMM, elen, e_ext,
					sub_q);
				seg_end  = sub_q == 3'(e_hn - 3'd1);
				nxt_st   = ST_ECOMM;
			end
			ST_ECOMM: begin
				if (!sub_q[2])
					cur_byte = ECOMM_PREFIX[{2'(2'd3 - sub_q[1:0]), 3'b000} +: 8];
				else begin
					case (sub_q[1:0])
						2'd0: cur_byte = ch_q[15:8];
						2'd1: cur_byte = ch_q[7:0];
						2'd2: cur_byte = cl_q[15:8];
						default: cur_byte = cl_q[7:0];
					endcase
				end
				entry_end = sub_q == 3'd7;
				seg_end   = entry_end && (idx_q == 8'(d_q.ne - 1'b1));
				nxt_st    = ST_IDLE;
			end
			default: ;
		endcase
	end

	assign step = comm_step(ch_q, cl_q, (st_q == ST_COMM) ? COMM_LIMIT : ECOMM_LIMIT);

	always_ff @(posedge clk) begin
		if (pop)
			d_q <= desc;
		if (pop) begin
			ch_q <= desc.chigh;
			cl_q <= desc.clow;
		end else if (adv && entry_end && (st_q == ST_COMM || st_q == ST_ECOMM)) begin
			ch_q <= step[31:16];
			cl_q <= step[15:0];
		end
		if (adv && flush) begin
			out_q.word        <= acc_new;
			out_q.byte_count  <= acc_n_new;
			out_q.last        <= img_last;
			out_q.total_bytes <= img_last ? d_q.total : '0;
		end
		if (pop || (adv && flush))
			acc_q <= '0;
		else if (adv)
			acc_q <= acc_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			sub_q       <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			acc_n_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && flush)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (pop) begin
				st_q    <= ST_PATH_HDR;
				sub_q   <= '0;
				idx_q   <= '0;
				pos_q   <= '0;
				acc_n_q <= '0;
			end else if (adv) begin
				pos_q   <= pos_q + 10'd1;
				acc_n_q <= flush ? 3'd0 : acc_n_new[2:0];
				if (img_last) begin
					st_q <= ST_IDLE;
				end else if (seg_end) begin
					st_q  <= nxt_st;
					sub_q <= '0;
					idx_q <= '0;
				end else if (entry_end) begin
					sub_q <= '0;
					idx_q <= idx_q + 8'd1;
				end else begin
					sub_q <= sub_q + 3'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/bgp_unique_path_attr_generator.sv
// The byte sequencer emits one image byte per cycle unless the output register is stalled;
// the front stays busy stepping the community counters once per community and extended
// community, and takes no new request until it is done.
// Reset (arst_n low): counters and registers take their start values, queue and output
// register empty; no memory needs clearing.
`default_nettype none
module bgp_unique_path_attr_generator #(
	parameter int MAX_PATH_LEN = bupa_pkg::MAX_PATH_LEN_DEF,
	parameter int MAX_COMMS    = bupa_pkg::MAX_COMMS_DEF,
	parameter int MAX_ECOMMS   = bupa_pkg::MAX_ECOMMS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Request channel
	input  wire logic         in_valid,
	output logic              in_ready,
	input  bupa_pkg::in_t     in_data,
	// Result channel
	output logic              out_valid,
	input  wire logic         out_ready,
	output bupa_pkg::out_t    out_data,
	// Register port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import bupa_pkg::*;

	cfg_wr_t   cfg_wr;
	cfg_regs_t cfg_regs;
	desc_t     push_data, pop_data;
	logic      push, full, pop, not_empty;
	reg_idx_t  rd_idx;

	// Registers sit on word addresses; write in the access phase.
	assign pready      = 1'b1;
	assign cfg_wr.en   = psel && penable && pwrite;
	assign cfg_wr.idx  = reg_idx_t'(paddr[4:2]);
	assign cfg_wr.data = pwdata[15:0];
	assign rd_idx      = reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (rd_idx)
			REG_PATH_LEN:        prdata = {24'd0, cfg_regs.path_len};
			REG_LOCAL_ASN:       prdata = {16'd0, cfg_regs.local_asn};
			REG_PATH_LOW_START:  prdata = {21'd0, cfg_regs.path_low_start};
			REG_PATH_HIGH_START: prdata = {16'd0, cfg_regs.path_high_start};
			REG_COMM_HIGH_START: prdata = {16'd0, cfg_regs.comm_high_start};
			REG_COMM_LOW_START:  prdata = {16'd0, cfg_regs.comm_low_start};
			default:             prdata = '0;
		endcase
	end

	// Front: clamp the request, size the image, snapshot and advance the counters.
	bupa_front #(
		.MAX_PATH_LEN (MAX_PATH_LEN),
		.MAX_COMMS    (MAX_COMMS),
		.MAX_ECOMMS   (MAX_ECOMMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_regs  (cfg_regs),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Hold image descriptors so the front can take the next item early.
	bupa_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	// Back: walk the image byte by byte and pack words into the output register.
	bupa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (not_empty),
		.pop       (pop),
		.desc      (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// File: hw/rtl/bupa_checker.sv
`default_nettype none
`include "bgp_unique_path_attr_generator_macros.svh"
module bupa_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  bupa_pkg::out_t  out_data
);
	import bupa_pkg::*;

	`BUPA_ASSERT_HOLD(a_out_hold, clk, arst_n, out_valid, out_ready, out_data)
	`BUPA_ASSERT(a_count_range, clk, arst_n, out_valid |-> out_data.byte_count != 4'd0 && out_data.byte_count <= 4'd8)
	`BUPA_ASSERT(a_mid_full, clk, arst_n, out_valid && !out_data.last |-> out_data.byte_count == 4'd8 && out_data.total_bytes == '0)
	`BUPA_ASSERT(a_last_total, clk, arst_n, out_valid && out_data.last |-> out_data.total_bytes != '0)

endmodule

bind bgp_unique_path_attr_generator bupa_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

// File: tb/bgp_unique_path_attr_generator_tb.sv
`timescale 1ns / 1ps
module bgp_unique_path_attr_generator_tb;
	import bupa_pkg::*;

	// Golden image builder: keeps its own copy of the registers and counters and
	// queues the words that each request must produce.
	class attr_image_predictor;
		logic [7:0]  cfg_path_len;
		logic [15:0] cfg_local_asn;
		logic [15:0] path_low, path_high, comm_high, comm_low;
		out_t        expected_words[$];
		int          mismatches;

		function void clear();
			cfg_path_len  = 8'd3;
			cfg_local_asn = 16'd0;
			path_low      = 16'd1000;
			path_high     = 16'd0;
			comm_high     = 16'd0;
			comm_low      = 16'd10000;
			expected_words.delete();
			mismatches    = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_PATH_LEN:        cfg_path_len = value[7:0];
				REG_LOCAL_ASN:       cfg_local_asn = value[15:0];
				REG_PATH_LOW_START:  path_low = {5'd0, value[10:0]};
				REG_PATH_HIGH_START: path_high = value[15:0];
				REG_COMM_HIGH_START: comm_high = value[15:0];
				REG_COMM_LOW_START:  comm_low = value[15:0];
				default: ;
			endcase
		endfunction

		function void comm_next(int limit);
			int nxt;
			nxt = int'(comm_low) + 1;
			if (nxt > limit) begin
				comm_low  = 16'd10000;
				comm_high = comm_high + 16'd1;
			end else begin
				comm_low = nxt[15:0];
			end
		endfunction

		function void put_header(logic [7:0] flags, logic [7:0] kind, int len,
			ref logic [7:0] img[$]);
			if (len > 255) begin
				img.push_back(flags | 8'h10);
				img.push_back(kind);
				img.push_back(len[15:8]);
				img.push_back(len[7:0]);
			end else begin
				img.push_back(flags);
				img.push_back(kind);
				img.push_back(len[7:0]);
			end
		endfunction

		function void note_request(in_t req);
			logic [7:0] img[$];
			int nc, ne, pl, total, nwords, pos, cnt;
			logic [15:0] asn;
			out_t w;
			nc = req.comm_count;
			ne = req.ecomm_count;
			pl = cfg_path_len;
			if (nc > MAX_COMMS_DEF) nc = MAX_COMMS_DEF;
			if (ne > MAX_ECOMMS_DEF) ne = MAX_ECOMMS_DEF;
			if (pl < 3) pl = 3;
			if (pl > MAX_PATH_LEN_DEF) pl = MAX_PATH_LEN_DEF;

			// AS_PATH: local ASN, filler from 50 upward, then the two path counters
			put_header(FLAG_TRANS, TYPE_AS_PATH, 2 + 2 * pl, img);
			img.push_back(SEG_SEQ);
			img.push_back(pl[7:0]);
			img.push_back(cfg_local_asn[15:8]);
			img.push_back(cfg_local_asn[7:0]);
			for (int i = 0; i + 3 < pl; i++) begin
				asn = 16'(50 + i);
				img.push_back(asn[15:8]);
				img.push_back(asn[7:0]);
			end
			img.push_back(path_low[15:8]);
			img.push_back(path_low[7:0]);
			img.push_back(path_high[15:8]);
			img.push_back(path_high[7:0]);
			path_low = path_low + 16'd1;
			if (path_low >= 16'd2000) begin
				path_low  = 16'd1000;
				path_high = path_high + 16'd1;
			end

			if (nc != 0) begin
				put_header(FLAG_OPT, TYPE_COMM, 4 * nc, img);
				for (int i = 0; i < nc; i++) begin
					img.push_back(comm_high[15:8]);
					img.push_back(comm_high[7:0]);
					img.push_back(comm_low[15:8]);
					img.push_back(comm_low[7:0]);
					comm_next(60000);
				end
			end
			if (ne != 0) begin
				put_header(FLAG_OPT, TYPE_ECOMM, 8 * ne, img);
				for (int i = 0; i < ne; i++) begin
					img.push_back(8'h40);
					img.push_back(8'h03);
					img.push_back(8'h01);
					img.push_back(8'h01);
					img.push_back(comm_high[15:8]);
					img.push_back(comm_high[7:0]);
					img.push_back(comm_low[15:8]);
					img.push_back(comm_low[7:0]);
					comm_next(50000);
				end
			end

			total = img.size();
			if (total > 512) total = 512;
			nwords = (total + 7) / 8;
			pos = 0;
			for (int i = 0; i < nwords; i++) begin
				cnt = total - pos;
				if (cnt > 8) cnt = 8;
				w = '0;
				for (int b = 0; b < 8; b++)
					w.word = {w.word[55:0], (b < cnt) ? img[pos + b] : 8'h00};
				w.byte_count  = 4'(cnt);
				w.last        = (i + 1 == nwords);
				w.total_bytes = w.last ? 10'(total) : 10'd0;
				expected_words.push_back(w);
				pos += cnt;
			end
		endfunction

		function void check_word(out_t got);
			out_t exp_w;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h", got);
				return;
			end
			exp_w = expected_words.pop_front();
			if (got.word !== exp_w.word || got.byte_count !== exp_w.byte_count ||
				got.last !== exp_w.last || got.total_bytes !== exp_w.total_bytes) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word mismatch: exp %h/%0d/%0b/%0d got %h/%0d/%0b/%0d",
						exp_w.word, exp_w.byte_count, exp_w.last, exp_w.total_bytes,
						got.word, got.byte_count, got.last, got.total_bytes);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b1;
	out_t        out_data;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic        pready;

	int tx_idle = 0;   // percent of cycles the sender holds back
	int rx_stall = 0;  // percent of cycles the receiver stalls

	attr_image_predictor image_pred;

	always #1 clk = ~clk;

	bgp_unique_path_attr_generator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Randomise the receiver's stalls on the falling edge.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rx_stall);

	// Watch both channels on the rising edge: note each accepted item, check each word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				image_pred.note_request(in_data);
			if (out_valid && out_ready)
				image_pred.check_word(out_data);
		end
	end

	// Present one item and hold it until accepted; returns on the accepting edge.
	task automatic send_request(logic [4:0] nc, logic [2:0] ne);
		int gap;
		@(negedge clk);
		gap = 0;
		while ($urandom_range(99) < tx_idle && gap < 20)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{comm_count: nc, ecomm_count: ne};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drop valid and wait until every expected word has arrived, then let the block settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (image_pred.expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		image_pred.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_idle_mode(int mode);
		case (mode)
			0: begin tx_idle = 0;  rx_stall = 0;  end
			1: begin tx_idle = 66; rx_stall = 0;  end
			2: begin tx_idle = 0;  rx_stall = 66; end
			default: begin tx_idle = 38; rx_stall = 38; end
		endcase
	endtask

	// Hard limit well above the slowest correct run.
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		image_pred = new();
		image_pred.clear();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings, then extremes of counts, path length and counters.
		set_idle_mode(0);
		send_request(5'd0, 3'd0);
		send_request(5'd1, 3'd1);
		send_request(5'd16, 3'd4);
		send_request(5'd31, 3'd7);   // both counts above their maxima: clamp
		send_request(5'd17, 3'd5);
		drain();
		write_reg(REG_PATH_LEN, 32'd0);      // below 3: treated as 3
		write_reg(REG_LOCAL_ASN, 32'hffff);
		write_reg(REG_PATH_LOW_START, 32'd1998);
		write_reg(REG_PATH_HIGH_START, 32'hffff);
		write_reg(REG_COMM_HIGH_START, 32'hffff);
		write_reg(REG_COMM_LOW_START, 32'd59998);
		send_request(5'd4, 3'd0);            // path and community wraps
		send_request(5'd2, 3'd2);
		drain();
		write_reg(REG_PATH_LEN, 32'd200);    // extended-length AS_PATH
		write_reg(REG_PATH_LOW_START, 32'd2047); // started high: returns to 1000
		write_reg(REG_COMM_LOW_START, 32'd49999);
		send_request(5'd0, 3'd4);            // extended community wrap at 50000
		send_request(5'd16, 3'd4);           // largest image
		drain();
		write_reg(REG_PATH_LEN, 32'd255);    // above max: treated as max
		write_reg(REG_COMM_LOW_START, 32'd65535);
		write_reg(REG_LOCAL_ASN, 32'd0);
		send_request(5'd3, 3'd1);
		drain();
		write_reg(REG_PATH_LEN, 32'd127);    // AS_PATH length exactly 256
		send_request(5'd0, 3'd0);
		send_request(5'd8, 3'd2);
		drain();

		// Random phases: new settings each phase, idle mode rotating.
		for (int ph = 0; ph < 8; ph++) begin
			int pl;
			write_reg(REG_LOCAL_ASN, $urandom_range(16'hffff));
			write_reg(REG_PATH_LOW_START, $urandom_range(11'h7ff));
			write_reg(REG_PATH_HIGH_START, $urandom_range(16'hffff));
			write_reg(REG_COMM_HIGH_START, $urandom_range(16'hffff));
			write_reg(REG_COMM_LOW_START, (ph % 2) ? $urandom_range(59990, 65535) :
				$urandom_range(16'hffff));
			case ($urandom_range(3))
				0: pl = $urandom_range(255);
				1: pl = $urandom_range(195, 200);
				default: pl = $urandom_range(3, 24);
			endcase
			write_reg(REG_PATH_LEN, pl);
			set_idle_mode(ph % 4);
			for (int n = 0; n < 40; n++) begin
				if ($urandom_range(3) == 0)
					send_request($urandom_range(31), $urandom_range(7));
				else
					send_request($urandom_range(16), $urandom_range(4));
			end
			drain();
		end

		// Leftover expectations count as failures.
		if (image_pred.expected_words.size() != 0)
			image_pred.mismatches++;
		if (image_pred.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
